// ----- sv/lookahead_true_peak_limiter_macros.svh -----
// Assertion macros shared by the limiter sources.
`ifndef LOOKAHEAD_TRUE_PEAK_LIMITER_MACROS_SVH
`define LOOKAHEAD_TRUE_PEAK_LIMITER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LTPL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LTPL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ltpl_pkg.sv -----
package ltpl_pkg;

   // Default structural sizes.
   localparam int RING_DEPTH_DEF   = 1024;
   localparam int SAMPLE_WIDTH_DEF = 24;

   // Fixed field widths.
   localparam int CEIL_W     = 23;
   localparam int COEF_W     = 24;
   localparam int DELAY_W    = 10;
   localparam int GAIN_W     = 24;
   localparam int QUO_W      = 23;
   localparam int PEAK_EXTRA = 8;

   // Fixed-point constants.
   localparam int GAIN_ONE_VAL = 1 << 23;
   localparam int COEF_ONE_VAL = 1 << 24;

   // Register reset values.
   localparam logic [CEIL_W-1:0]  CEIL_RESET    = 23'd4182251;
   localparam logic [COEF_W-1:0]  ATTACK_RESET  = 24'hFFFFFF;
   localparam logic [COEF_W-1:0]  RELEASE_RESET = 24'hFFFFFF;
   localparam logic [DELAY_W-1:0] DELAY_RESET   = 10'd240;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_CEILING = 2'd0,
      REG_ATTACK  = 2'd1,
      REG_RELEASE = 2'd2,
      REG_DELAY   = 2'd3
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD_A1, ST_RD_A2, ST_LANE1, ST_LANE2, ST_LANE3,
      ST_MERGE, ST_DIV, ST_SM1, ST_SM2, ST_SM3, ST_MUL_L, ST_MUL_R, ST_FIN,
      ST_OUT
   } ltpl_state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- sv/ltpl_req_if.sv -----
interface ltpl_req_if
   import ltpl_pkg::*;
   #(parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_left;
   logic signed [SAMPLE_WIDTH-1:0] in_right;

   modport source (output valid, output in_left, output in_right, input ready);
   modport sink (input valid, input in_left, input in_right, output ready);
endinterface

// ----- sv/ltpl_rsp_if.sv -----
interface ltpl_rsp_if
   import ltpl_pkg::*;
   #(parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_left;
   logic signed [SAMPLE_WIDTH-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ----- sv/ltpl_ram.sv -----
module ltpl_ram
   import ltpl_pkg::*;
   #(
   parameter int WIDTH = SAMPLE_WIDTH_DEF,
   parameter int DEPTH = RING_DEPTH_DEF
   ) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/ltpl_peak_lane.sv -----
module ltpl_peak_lane
   import ltpl_pkg::*;
   #(parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF) (
   input  logic                                  clock,
   input  logic signed [SAMPLE_WIDTH-1:0]        p0,
   input  logic signed [SAMPLE_WIDTH-1:0]        p1,
   input  logic signed [SAMPLE_WIDTH-1:0]        p2,
   input  logic signed [SAMPLE_WIDTH-1:0]        p3,
   output logic [SAMPLE_WIDTH+PEAK_EXTRA-1:0]    peak
);

   localparam int CW = SAMPLE_WIDTH + 5;
   localparam int NW = SAMPLE_WIDTH + 12;
   localparam int PW = SAMPLE_WIDTH + PEAK_EXTRA;

   logic signed [CW-1:0] e0, e1, e2, e3;
   logic signed [CW-1:0] a_in, b_in, c_in;
   logic [PW-1:0]        m1, m2, m12_in;
   logic signed [CW-1:0] a_ff, b_ff, c_ff;
   logic signed [CW-1:0] p1_s1_ff;
   logic [PW-1:0]        m12_s1_ff, m12_s2_ff;
   logic signed [NW-1:0] xa, xb, xc, xp;
   logic signed [NW-1:0] n1_in, n2_in, n3_in;
   logic signed [NW-1:0] n1_ff, n2_ff, n3_ff;
   logic [PW-1:0]        r1, r2, r3, peak_in, peak_ff;

   // Rounded magnitude of an interpolation numerator scaled by 128.
   function automatic logic [PW-1:0] round_mag(input logic signed [NW-1:0] n);
      logic [NW-1:0] mag;
      logic [NW-1:0] sum;
      mag = n[NW-1] ? NW'(-n) : NW'(n);
      sum = mag + NW'(64);
      return PW'(sum >> 7);
   endfunction

   // Stage one: spline coefficients and the larger magnitude of p1 and p2.
   always_comb begin
      e0 = CW'(p0);
      e1 = CW'(p1);
      e2 = CW'(p2);
      e3 = CW'(p3);
      a_in = e2 - e0;
      b_in = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c_in = (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
      m1 = e1[CW-1] ? PW'(-e1) : PW'(e1);
      m2 = e2[CW-1] ? PW'(-e2) : PW'(e2);
      m12_in = (m2 > m1) ? m2 : m1;
   end

   // Stage two: numerators at t of one, two and three quarters.
   always_comb begin
      xa = NW'(a_ff);
      xb = NW'(b_ff);
      xc = NW'(c_ff);
      xp = NW'(p1_s1_ff) <<< 7;
      n1_in = xp + (xa <<< 4) + (xb <<< 2) + xc;
      n2_in = xp + (xa <<< 5) + (xb <<< 4) + (xc <<< 3);
      n3_in = xp + (xa <<< 5) + (xa <<< 4) + (xb <<< 5) + (xb <<< 2)
            + (xc <<< 4) + (xc <<< 3) + (xc <<< 1) + xc;
   end

   // Stage three: the largest of all candidates.
   always_comb begin
      r1 = round_mag(n1_ff);
      r2 = round_mag(n2_ff);
      r3 = round_mag(n3_ff);
      peak_in = m12_s2_ff;
      if (r1 > peak_in) begin
         peak_in = r1;
      end
      if (r2 > peak_in) begin
         peak_in = r2;
      end
      if (r3 > peak_in) begin
         peak_in = r3;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      p1_s1_ff  <= e1;
      m12_s1_ff <= m12_in;
      n1_ff     <= n1_in;
      n2_ff     <= n2_in;
      n3_ff     <= n3_in;
      m12_s2_ff <= m12_s1_ff;
      peak_ff   <= peak_in;
   end

   assign peak = peak_ff;

endmodule

// ----- sv/ltpl_divider.sv -----
module ltpl_divider
   import ltpl_pkg::*;
   #(parameter int DIVISOR_W = SAMPLE_WIDTH_DEF + PEAK_EXTRA) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CEIL_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [QUO_W-1:0]     quotient,
   output div_status_type       status
);

   localparam int RW = DIVISOR_W + 1;
   localparam int CNT_W = $clog2(QUO_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [RW-1:0]        div_ff, div_in;
   logic [RW-1:0]        rem2;

   // Restoring division, one quotient bit per cycle. The dividend is the
   // ceiling times 2^23 and is below divisor times 2^23, so the ceiling is
   // the starting remainder and the zero bits below it are shifted in.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem2    = {rem_ff[RW-2:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = RW'(dividend);
         quo_in  = '0;
         div_in  = RW'(divisor);
      end else if (busy_ff) begin
         if (rem2 >= div_ff) begin
            rem_in = rem2 - div_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem2;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- sv/lookahead_true_peak_limiter.sv -----
// Each item is read from the rings, passed through the peak lanes, divided only when the
// peak exceeds the ceiling and gain reduction is needed, then smoothed and multiplied.
// A new item is accepted only once the last result is in the response register; the 23-step
// serial divider and the one shared multiplier do the smoothing and both gain products.
// Reset is synchronous and active high; after it a clearing pass writes zeros
// through every ring address, during which no item is accepted.
`include "lookahead_true_peak_limiter_macros.svh"

module lookahead_true_peak_limiter
   import ltpl_pkg::*;
   #(
   parameter int RING_DEPTH   = RING_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
   ) (
   input  logic        clock,
   input  logic        reset,
   ltpl_req_if.sink    req_if,
   ltpl_rsp_if.source  rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int AW  = $clog2(RING_DEPTH);
   localparam int PW  = SW + PEAK_EXTRA;
   localparam int MA  = ((SW > COEF_W + 1) ? SW : COEF_W + 1) + 1;
   localparam int PRW = 2 * MA;
   localparam int XW  = (AW > DELAY_W) ? AW : DELAY_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic signed [PRW-1:0] GAIN_ONE_P = PRW'(GAIN_ONE_VAL);

   // Configuration registers.
   logic [CEIL_W-1:0]  ceil_ff;
   logic [COEF_W-1:0]  attack_ff;
   logic [COEF_W-1:0]  release_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic               csr_write;

   // Sequencer and datapath state.
   ltpl_state_type        state_ff, state_in;
   logic [AW-1:0]         clr_ff;
   logic [AW-1:0]         wp_ff;
   logic signed [SW-1:0]  cur_l_ff, cur_r_ff;
   logic signed [SW-1:0]  prev_l_ff, prev_r_ff;
   logic signed [SW-1:0]  p2_l_ff, p2_r_ff, p3_l_ff, p3_r_ff;
   logic signed [SW-1:0]  d_l_ff, d_r_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [GAIN_W-1:0]     target_ff;
   logic signed [PRW-1:0] mul_ff, acc_ff;
   logic signed [SW-1:0]  res_l_ff, res_r_ff;
   logic                  rsp_valid_ff;
   logic signed [SW-1:0]  rsp_l_ff, rsp_r_ff;

   // Ring addressing.
   logic [AW-1:0]  a1, a2, rp, delay_sat;
   logic [XW-1:0]  delay_ext;
   logic [AW:0]    rp_wide;
   logic           delay_zero;

   // Ring ports.
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [SW-1:0]  ram_wdata_l, ram_wdata_r, ram_rdata_l, ram_rdata_r;

   // Lanes, merge and divider.
   logic [PW-1:0]      peak_l, peak_r, peak_max;
   logic               limit;
   logic               div_start;
   logic [QUO_W-1:0]   quotient;
   div_status_type     div_status;

   // Shared multiplier and smoothing.
   logic [COEF_W-1:0]     coef_sel;
   logic [COEF_W:0]       coef_comp;
   logic signed [MA-1:0]  mul_a, mul_b;
   logic signed [PRW-1:0] smooth_sum, smooth_sh;
   logic [GAIN_W-1:0]     gain_next;
   logic signed [SW-1:0]  sat_res;
   logic                  out_free;

   // Round a gain product by 2^23 and saturate to the sample range.
   function automatic logic signed [SW-1:0] round_sat(input logic signed [PRW-1:0] p);
      logic signed [PRW-1:0] r;
      logic [PRW-SW:0]       top;
      r = (p + (PRW'(1) <<< 22)) >>> 23;
      top = r[PRW-1:SW-1];
      if ((&top) || !(|top)) begin
         return r[SW-1:0];
      end
      return r[PRW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
   endfunction

   // APB register file.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff    <= CEIL_RESET;
         attack_ff  <= ATTACK_RESET;
         release_ff <= RELEASE_RESET;
         delay_ff   <= DELAY_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_CEILING: ceil_ff    <= csr_pwdata[CEIL_W-1:0];
            REG_ATTACK:  attack_ff  <= csr_pwdata[COEF_W-1:0];
            REG_RELEASE: release_ff <= csr_pwdata[COEF_W-1:0];
            REG_DELAY:   delay_ff   <= csr_pwdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_CEILING: csr_prdata = 32'(ceil_ff);
         REG_ATTACK:  csr_prdata = 32'(attack_ff);
         REG_RELEASE: csr_prdata = 32'(release_ff);
         REG_DELAY:   csr_prdata = 32'(delay_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Ring addresses: two past the write pointer and the delayed read point.
   always_comb begin
      a1 = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
      a2 = (a1 == LAST_ADDR) ? '0 : a1 + AW'(1);
      delay_ext = XW'(delay_ff);
      delay_sat = (delay_ext > XW'(RING_DEPTH - 1)) ? LAST_ADDR : AW'(delay_ext);
      delay_zero = (delay_sat == '0);
      if (wp_ff >= delay_sat) begin
         rp_wide = (AW+1)'(wp_ff) - (AW+1)'(delay_sat);
      end else begin
         rp_wide = (AW+1)'(wp_ff) + (AW+1)'(RING_DEPTH) - (AW+1)'(delay_sat);
      end
      rp = rp_wide[AW-1:0];
   end

   // Sample rings, one per channel.
   ltpl_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_ring_l (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata_l),
      .raddr (ram_raddr),
      .rdata (ram_rdata_l)
   );

   ltpl_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_ring_r (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata_r),
      .raddr (ram_raddr),
      .rdata (ram_rdata_r)
   );

   // Peak estimators, one lane per channel.
   ltpl_peak_lane #(.SAMPLE_WIDTH(SW)) u_lane_l (
      .clock (clock),
      .p0    (prev_l_ff),
      .p1    (cur_l_ff),
      .p2    (p2_l_ff),
      .p3    (p3_l_ff),
      .peak  (peak_l)
   );

   ltpl_peak_lane #(.SAMPLE_WIDTH(SW)) u_lane_r (
      .clock (clock),
      .p0    (prev_r_ff),
      .p1    (cur_r_ff),
      .p2    (p2_r_ff),
      .p3    (p3_r_ff),
      .peak  (peak_r)
   );

   // Merge the lanes and decide whether the gain must come down.
   assign peak_max = (peak_l > peak_r) ? peak_l : peak_r;
   assign limit    = peak_max > PW'(ceil_ff);

   ltpl_divider #(.DIVISOR_W(PW)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ceil_ff),
      .divisor  (peak_max),
      .quotient (quotient),
      .status   (div_status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:  if (req_if.valid) state_in = ST_RD_A1;
         ST_RD_A1: state_in = ST_RD_A2;
         ST_RD_A2: state_in = ST_LANE1;
         ST_LANE1: state_in = ST_LANE2;
         ST_LANE2: state_in = ST_LANE3;
         ST_LANE3: state_in = ST_MERGE;
         ST_MERGE: state_in = limit ? ST_DIV : ST_SM1;
         ST_DIV:   if (div_status.done) state_in = ST_SM1;
         ST_SM1:   state_in = ST_SM2;
         ST_SM2:   state_in = ST_SM3;
         ST_SM3:   state_in = ST_MUL_L;
         ST_MUL_L: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_FIN;
         ST_FIN:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_if.ready = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_wdata_l  = cur_l_ff;
      ram_wdata_r  = cur_r_ff;
      ram_raddr    = a1;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_ff;
            ram_wdata_l = '0;
            ram_wdata_r = '0;
         end
         ST_IDLE:  req_if.ready = 1'b1;
         ST_RD_A1: ram_raddr = a2;
         ST_RD_A2: ram_raddr = rp;
         ST_LANE1: ram_we = 1'b1;
         ST_MERGE: div_start = limit;
         ST_SM1: begin
            mul_a = MA'($signed({1'b0, coef_sel}));
            mul_b = MA'($signed({1'b0, gain_ff}));
         end
         ST_SM2: begin
            mul_a = MA'($signed({1'b0, coef_comp}));
            mul_b = MA'($signed({1'b0, target_ff}));
         end
         ST_MUL_L: begin
            mul_a = MA'(d_l_ff);
            mul_b = MA'($signed({1'b0, gain_ff}));
         end
         ST_MUL_R: begin
            mul_a = MA'(d_r_ff);
            mul_b = MA'($signed({1'b0, gain_ff}));
         end
         default: ;
      endcase
   end

   // Smoothing step and the gain clamp.
   always_comb begin
      coef_sel   = (target_ff < gain_ff) ? attack_ff : release_ff;
      coef_comp  = (COEF_W+1)'(COEF_ONE_VAL) - {1'b0, coef_sel};
      smooth_sum = acc_ff + mul_ff + (PRW'(1) <<< 23);
      smooth_sh  = smooth_sum >>> 24;
      gain_next  = (smooth_sh > GAIN_ONE_P) ? GAIN_W'(GAIN_ONE_VAL)
                                            : smooth_sh[GAIN_W-1:0];
      sat_res    = round_sat(mul_ff);
      out_free   = !rsp_valid_ff || rsp_if.ready;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         gain_ff      <= GAIN_W'(GAIN_ONE_VAL);
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_MERGE) begin
            wp_ff     <= a1;
            prev_l_ff <= cur_l_ff;
            prev_r_ff <= cur_r_ff;
         end
         if (state_ff == ST_SM3) begin
            gain_ff <= gain_next;
         end
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mul_ff <= PRW'(mul_a * mul_b);
      if (req_if.valid && req_if.ready) begin
         cur_l_ff <= req_if.in_left;
         cur_r_ff <= req_if.in_right;
      end
      case (state_ff)
         ST_RD_A1: begin
            p2_l_ff <= ram_rdata_l;
            p2_r_ff <= ram_rdata_r;
         end
         ST_RD_A2: begin
            p3_l_ff <= ram_rdata_l;
            p3_r_ff <= ram_rdata_r;
         end
         ST_LANE1: begin
            d_l_ff <= delay_zero ? cur_l_ff : ram_rdata_l;
            d_r_ff <= delay_zero ? cur_r_ff : ram_rdata_r;
         end
         ST_MERGE: if (!limit) target_ff <= GAIN_W'(GAIN_ONE_VAL);
         ST_DIV:   if (div_status.done) target_ff <= GAIN_W'(quotient);
         ST_SM2:   acc_ff <= mul_ff;
         ST_MUL_R: res_l_ff <= sat_res;
         ST_FIN:   res_r_ff <= sat_res;
         ST_OUT: begin
            if (out_free) begin
               rsp_l_ff <= res_l_ff;
               rsp_r_ff <= res_r_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_left  = rsp_l_ff;
   assign rsp_if.out_right = rsp_r_ff;

   // Checks on the sequencer and the gain path.
   `LTPL_ASSERT_NOW(a_gain_bound, clock, reset, 1'b1, gain_ff <= GAIN_W'(GAIN_ONE_VAL),
      "smoothed gain exceeds unity")
   `LTPL_ASSERT_NEXT(a_accept_starts, clock, reset, req_if.valid && req_if.ready,
      state_ff == ST_RD_A1, "accepted item did not start the read sequence")
   `LTPL_ASSERT_NOW(a_div_owner, clock, reset, div_status.done,
      state_ff == ST_DIV, "divider finished outside the division wait")
   `LTPL_ASSERT_NOW(a_clear_blocks, clock, reset, state_ff == ST_CLEAR,
      !req_if.ready && !rsp_if.valid, "item traffic during the ring clearing pass")

endmodule
